// ===== rtl/ptd_pkg.sv =====
`default_nettype none

package ptd_pkg;

   // fixed field widths
   localparam int DATA_W      = 32;
   localparam int TASK_IDX_W  = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int MAX_TASKS   = 6;

   // register map: indexes below the suspend mask select a task period
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD_0     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSPEND_MASK = 3'd6;

   // reset periods, in time units
   localparam logic [DATA_W-1:0] PERIOD_RESET [MAX_TASKS] = '{
      32'd1000000, 32'd250, 32'd1000, 32'd1000, 32'd1000, 32'd1000
   };

   // item codes
   localparam logic MODE_POLL  = 1'b0;
   localparam logic MODE_DONE  = 1'b1;
   localparam logic KIND_GRANT = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [DATA_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [TASK_IDX_W-1:0] task_index;
      logic [DATA_W-1:0]     start_interval;
      logic [DATA_W-1:0]     run_time;
      logic [DATA_W-1:0]     run_time_max;
      logic [DATA_W-1:0]     run_time_min;
      logic [DATA_W-1:0]     sum_run_time;
      logic [DATA_W-1:0]     sum_of_maxima;
      logic [DATA_W-1:0]     sum_of_minima;
   } rsp_type;

   // one task entry of the state memory
   typedef struct packed {
      logic [DATA_W-1:0] last_start;
      logic [DATA_W-1:0] max_run;
      logic [DATA_W-1:0] min_run;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{
      last_start: '0,
      max_run:    '0,
      min_run:    '1
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMMIT,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/ptd_ram.sv =====
`default_nettype none

module ptd_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 6,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/periodic_task_dispatcher_unit.sv =====
`default_nettype none

// Cooperative periodic task dispatcher. A poll item grants the task at the
// scan position if it is ready; a done item closes the running task and
// reports its run time with per-task and global statistics. Every accepted
// item that is not ignored and is not a grant is followed by a rescan that
// marks due tasks ready and moves the scan position. Per-task start time,
// max and min live in one state memory with a registered read; the
// rescan streams the entries out one per cycle. busy stays high from the
// accept edge until the block can take the next item: a poll that grants
// passes through the read state only, a poll that rescans through read and
// scan, a done item through read, commit and scan, and an item that is
// ignored (a poll while a task runs, a done while none runs) does not
// raise it. Results come out on rsp_data for exactly one cycle with
// rsp_valid high; the receiver has no way to stall them. Reset values of
// the memory are supplied by per-entry valid bits, so no clearing pass is
// needed. Configuration writes are always taken.

module periodic_task_dispatcher_unit #(
   parameter int NUM_TASKS = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire ptd_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   output ptd_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ptd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ptd_pkg::DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

   // control state
   ptd_pkg::state_type state_ff, state_in;
   logic                 running_ff, running_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [NUM_TASKS-1:0] ready_ff, ready_in;
   logic [NUM_TASKS-1:0] ent_valid_ff, ent_valid_in;
   logic [IDX_W-1:0]     issue_ff, issue_in;
   logic                 issue_active_ff, issue_active_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 eval_valid_ff, eval_valid_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ptd_pkg::DATA_W-1:0] total_run_ff, total_run_in;
   logic [ptd_pkg::DATA_W-1:0] total_max_ff, total_max_in;
   logic [ptd_pkg::DATA_W-1:0] total_min_ff, total_min_in;

   // payload
   ptd_pkg::req_type     cmd_ff, cmd_in;
   ptd_pkg::entry_type   ent_ff, ent_in;
   logic [ptd_pkg::DATA_W-1:0] rt_ff, rt_in;
   ptd_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // configuration
   logic [ptd_pkg::DATA_W-1:0] period_ff [NUM_TASKS];
   logic [ptd_pkg::MAX_TASKS-1:0] suspend_ff;

   // memory port
   logic                       ram_we;
   logic [IDX_W-1:0]           ram_waddr;
   ptd_pkg::entry_type         ram_wdata;
   logic                       ram_re;
   logic [IDX_W-1:0]           ram_raddr;
   logic [ptd_pkg::ENTRY_W-1:0] ram_rdata;

   // combinational helpers
   ptd_pkg::entry_type         ent_rd;
   logic [ptd_pkg::DATA_W-1:0] elapsed;
   logic                       due;
   logic [ptd_pkg::DATA_W-1:0] max_new;
   logic [ptd_pkg::DATA_W-1:0] min_new;

   ptd_ram #(
      .WIDTH (ptd_pkg::ENTRY_W),
      .DEPTH (NUM_TASKS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TASKS; k++) begin
            period_ff[k] <= ptd_pkg::PERIOD_RESET[k];
         end
         suspend_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == ptd_pkg::REG_SUSPEND_MASK) begin
            suspend_ff <= csr_wdata[ptd_pkg::MAX_TASKS-1:0];
         end else if (csr_index >= ptd_pkg::REG_PERIOD_0 &&
                      csr_index < ptd_pkg::CSR_INDEX_W'(NUM_TASKS)) begin
            period_ff[csr_index[IDX_W-1:0]] <= csr_wdata;
         end
      end
   end

   // entry as read, with reset value for entries never written
   assign ent_rd  = rd_valid_ff ? ptd_pkg::entry_type'(ram_rdata) : ptd_pkg::ENTRY_RESET;
   assign elapsed = cmd_ff.now - ent_rd.last_start;
   assign due     = (elapsed >= period_ff[eval_idx_ff]) && !suspend_ff[eval_idx_ff];
   assign max_new = (rt_ff > ent_ff.max_run) ? rt_ff : ent_ff.max_run;
   assign min_new = (rt_ff < ent_ff.min_run) ? rt_ff : ent_ff.min_run;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      running_in      = running_ff;
      pos_in          = pos_ff;
      ready_in        = ready_ff;
      ent_valid_in    = ent_valid_ff;
      issue_in        = issue_ff;
      issue_active_in = issue_active_ff;
      eval_idx_in     = eval_idx_ff;
      eval_valid_in   = 1'b0;
      rd_valid_in     = rd_valid_ff;
      rsp_valid_in    = 1'b0;
      total_run_in    = total_run_ff;
      total_max_in    = total_max_ff;
      total_min_in    = total_min_ff;
      cmd_in          = cmd_ff;
      ent_in          = ent_ff;
      rt_in           = rt_ff;
      rsp_data_in     = rsp_data_ff;
      ram_we          = 1'b0;
      ram_waddr       = pos_ff;
      ram_wdata       = ent_ff;
      ram_re          = 1'b0;
      ram_raddr       = pos_ff;

      case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in = req_data;
               // items that do not fit the current state are dropped
               if ((req_data.mode == ptd_pkg::MODE_POLL && !running_ff) ||
                   (req_data.mode == ptd_pkg::MODE_DONE && running_ff)) begin
                  ram_re      = 1'b1;
                  ram_raddr   = pos_ff;
                  rd_valid_in = ent_valid_ff[pos_ff];
                  state_in    = ptd_pkg::ST_READ;
               end
            end
         end

         ptd_pkg::ST_READ: begin
            if (cmd_ff.mode == ptd_pkg::MODE_POLL) begin
               if (ready_ff[pos_ff]) begin
                  // grant: report interval and record the new start
                  ram_we                = 1'b1;
                  ram_waddr             = pos_ff;
                  ram_wdata             = ent_rd;
                  ram_wdata.last_start  = cmd_ff.now;
                  ent_valid_in[pos_ff]  = 1'b1;
                  ready_in[pos_ff]      = 1'b0;
                  running_in            = 1'b1;
                  rsp_valid_in          = 1'b1;
                  rsp_data_in           = '0;
                  rsp_data_in.kind      = ptd_pkg::KIND_GRANT;
                  rsp_data_in.task_index = ptd_pkg::TASK_IDX_W'(pos_ff);
                  rsp_data_in.start_interval = cmd_ff.now - ent_rd.last_start;
                  state_in              = ptd_pkg::ST_IDLE;
               end else begin
                  issue_in        = '0;
                  issue_active_in = 1'b1;
                  state_in        = ptd_pkg::ST_SCAN;
               end
            end else begin
               ent_in   = ent_rd;
               rt_in    = cmd_ff.now - ent_rd.last_start;
               state_in = ptd_pkg::ST_COMMIT;
            end
         end

         ptd_pkg::ST_COMMIT: begin
            // completion: update per-task extremes and global sums
            ram_we               = 1'b1;
            ram_waddr            = pos_ff;
            ram_wdata.last_start = ent_ff.last_start;
            ram_wdata.max_run    = max_new;
            ram_wdata.min_run    = min_new;
            ent_valid_in[pos_ff] = 1'b1;
            total_run_in         = total_run_ff + rt_ff;
            total_max_in         = total_max_ff + max_new;
            total_min_in         = total_min_ff + min_new;
            running_in           = 1'b0;
            rsp_valid_in         = 1'b1;
            rsp_data_in          = '0;
            rsp_data_in.kind     = ptd_pkg::KIND_DONE;
            rsp_data_in.task_index = ptd_pkg::TASK_IDX_W'(pos_ff);
            rsp_data_in.run_time     = rt_ff;
            rsp_data_in.run_time_max = max_new;
            rsp_data_in.run_time_min = min_new;
            rsp_data_in.sum_run_time  = total_run_ff + rt_ff;
            rsp_data_in.sum_of_maxima = total_max_ff + max_new;
            rsp_data_in.sum_of_minima = total_min_ff + min_new;
            issue_in             = '0;
            issue_active_in      = 1'b1;
            state_in             = ptd_pkg::ST_SCAN;
         end

         ptd_pkg::ST_SCAN: begin
            // stream entries out of the memory, one per cycle
            if (issue_active_ff) begin
               ram_re        = 1'b1;
               ram_raddr     = issue_ff;
               rd_valid_in   = ent_valid_ff[issue_ff];
               eval_valid_in = 1'b1;
               eval_idx_in   = issue_ff;
               if (issue_ff == LAST_IDX) begin
                  issue_active_in = 1'b0;
               end else begin
                  issue_in = issue_ff + 1'b1;
               end
            end
            // evaluate the entry read last cycle
            if (eval_valid_ff) begin
               if (due) begin
                  ready_in[eval_idx_ff] = 1'b1;
               end
               if (due && pos_ff > eval_idx_ff) begin
                  pos_in          = eval_idx_ff;
                  issue_active_in = 1'b0;
                  eval_valid_in   = 1'b0;
                  state_in        = ptd_pkg::ST_IDLE;
               end else if (eval_idx_ff == LAST_IDX) begin
                  pos_in   = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
                  state_in = ptd_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ptd_pkg::ST_IDLE;
         running_ff      <= 1'b0;
         pos_ff          <= '0;
         ready_ff        <= '1;
         ent_valid_ff    <= '0;
         issue_ff        <= '0;
         issue_active_ff <= 1'b0;
         eval_idx_ff     <= '0;
         eval_valid_ff   <= 1'b0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         total_run_ff    <= '0;
         total_max_ff    <= '0;
         total_min_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         running_ff      <= running_in;
         pos_ff          <= pos_in;
         ready_ff        <= ready_in;
         ent_valid_ff    <= ent_valid_in;
         issue_ff        <= issue_in;
         issue_active_ff <= issue_active_in;
         eval_idx_ff     <= eval_idx_in;
         eval_valid_ff   <= eval_valid_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         total_run_ff    <= total_run_in;
         total_max_ff    <= total_max_in;
         total_min_ff    <= total_min_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ent_ff      <= ent_in;
      rt_ff       <= rt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ptd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ptd_checker.sv =====
`default_nettype none

module ptd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire ptd_pkg::rsp_type                rsp_data
);

   // no result comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // a result only follows a cycle of work
   a_result_needs_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   // an idle cycle with no new item gives no result next cycle
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_valid)
      else $error("result without an item");

   // results are never back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // a completion's run time lies between its updated min and max
   a_run_time_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == ptd_pkg::KIND_DONE) |->
         (rsp_data.run_time_min <= rsp_data.run_time &&
          rsp_data.run_time <= rsp_data.run_time_max))
      else $error("run time outside its min and max");

endmodule

bind periodic_task_dispatcher_unit ptd_checker u_ptd_checker (.*);

`default_nettype wire
